// ===== sv/sle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg: shared types and constants of the list engine
// Command and status codes, field widths, and the command and status groups
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int DEF_CAPACITY = 128;
  localparam int CMD_W        = 3;
  localparam int POS_W        = 8;
  localparam int DATA_W       = 32;
  localparam int ST_W         = 2;

  typedef enum logic [CMD_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_LOCATE = 3'd4,
    OP_MAXEND = 3'd5,
    OP_READ   = 3'd6
  } opcode_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_t;

  // Kind of walk the element mover performs.
  typedef enum logic [1:0] {
    MV_SCAN = 2'd0,
    MV_UP   = 2'd1,
    MV_DEL  = 2'd2,
    MV_MAX  = 2'd3
  } mv_kind_t;

  typedef struct packed {
    logic     cap;
    logic     clr_len;
    logic     inc_len;
    logic     dec_len;
    logic     wr_tail;
    logic     wr_pos;
    logic     wr_best;
    logic     cap_rd;
    logic     mv_start;
    mv_kind_t mv_kind;
    logic     set_status;
    status_t  status;
    logic     take_found;
    logic     take_best;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    bad_ins;
    logic    bad_pos;
    logic    full;
    logic    empty;
    logic    busy;
    logic    out_free;
  } dp_sts_t;

endpackage

// ===== sv/sle_cmd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_cmd_if: command request channel
// Valid/ready channel carrying one list command request.
// ----------------------------------------------------------------------------
interface sle_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [sle_pkg::CMD_W-1:0]         command;
  logic [sle_pkg::POS_W-1:0]         position;
  logic signed [sle_pkg::DATA_W-1:0] value;

  modport source(output valid, command, position, value, input ready);
  modport sink(input valid, command, position, value, output ready);
endinterface

// ===== sv/sle_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_rsp_if: result channel
// Valid/ready channel carrying one result per command request.
// ----------------------------------------------------------------------------
interface sle_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [sle_pkg::ST_W-1:0]          status;
  logic signed [sle_pkg::DATA_W-1:0] data_out;
  logic [sle_pkg::POS_W-1:0]         found_at;
  logic [sle_pkg::POS_W-1:0]         length_now;

  modport source(output valid, status, data_out, found_at, length_now, input ready);
  modport sink(input valid, status, data_out, found_at, length_now, output ready);
endinterface

// ===== sv/sle_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_datapath: element store, length, mover and result registers
// Holds the list memory with one write and one registered read port, a mover
// that walks the store one element per cycle, and the output register.
// ----------------------------------------------------------------------------
module sle_datapath #(
  parameter int CAPACITY = sle_pkg::DEF_CAPACITY
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sle_pkg::dp_cmd_t                  cmd,
  output sle_pkg::dp_sts_t                  sts,
  input  logic [sle_pkg::CMD_W-1:0]         in_command,
  input  logic [sle_pkg::POS_W-1:0]         in_position,
  input  logic signed [sle_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sle_pkg::ST_W-1:0]          out_status,
  output logic signed [sle_pkg::DATA_W-1:0] out_data,
  output logic [sle_pkg::POS_W-1:0]         out_found,
  output logic [sle_pkg::POS_W-1:0]         out_length
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int EW = ((LW > sle_pkg::POS_W) ? LW : sle_pkg::POS_W) + 1;
  localparam logic [LW-1:0] ONE = LW'(1);
  localparam logic [LW-1:0] CAP = LW'(CAPACITY);

  logic signed [sle_pkg::DATA_W-1:0] mem [CAPACITY];

  logic [sle_pkg::CMD_W-1:0]         cmd_r;
  logic [sle_pkg::POS_W-1:0]         pos_r;
  logic signed [sle_pkg::DATA_W-1:0] val_r;
  logic [LW-1:0]                     len_r;

  logic [LW-1:0]                     src_r;
  logic [LW-1:0]                     cnt_r;
  logic [LW-1:0]                     tag_r;
  logic                              pend_r;
  sle_pkg::mv_kind_t                 kind_r;

  logic signed [sle_pkg::DATA_W-1:0] rdata_r;
  logic                              found_v_r;
  logic [LW-1:0]                     found_idx_r;
  logic signed [sle_pkg::DATA_W-1:0] best_val_r;
  logic [LW-1:0]                     best_idx_r;

  sle_pkg::status_t                  res_status_r;
  logic signed [sle_pkg::DATA_W-1:0] res_data_r;
  logic [sle_pkg::POS_W-1:0]         res_found_r;

  logic                              out_valid_r;
  logic [sle_pkg::ST_W-1:0]          out_status_r;
  logic signed [sle_pkg::DATA_W-1:0] out_data_r;
  logic [sle_pkg::POS_W-1:0]         out_found_r;
  logic [sle_pkg::POS_W-1:0]         out_length_r;

  logic [EW-1:0]                     pos_e;
  logic [EW-1:0]                     len_e;
  logic [LW-1:0]                     p0;
  logic                              mv_rd;
  logic                              move_wr;
  logic [LW-1:0]                     dst;
  logic [AW-1:0]                     raddr;
  logic                              we;
  logic [AW-1:0]                     waddr;
  logic signed [sle_pkg::DATA_W-1:0] wdata;
  logic [LW-1:0]                     src_nxt;
  logic [LW-1:0]                     cnt_nxt;

  assign pos_e = EW'(pos_r);
  assign len_e = EW'(len_r);
  assign p0    = LW'(pos_e - EW'(1));

  assign sts.op       = sle_pkg::opcode_t'(cmd_r);
  assign sts.bad_ins  = (pos_r == '0) || (pos_e > (len_e + EW'(1)));
  assign sts.bad_pos  = (pos_r == '0) || (pos_e > len_e);
  assign sts.full     = (len_r >= CAP);
  assign sts.empty    = (len_r == '0);
  assign sts.busy     = (cnt_r != '0) || pend_r;
  assign sts.out_free = !out_valid_r || out_ready;

  // The mover reads while it has elements left; a single read otherwise
  // targets the requested position.
  assign mv_rd   = (cnt_r != '0);
  assign raddr   = mv_rd ? src_r[AW-1:0] : p0[AW-1:0];
  assign move_wr = pend_r && (kind_r != sle_pkg::MV_SCAN);
  assign dst     = (kind_r == sle_pkg::MV_UP) ? (tag_r + ONE) : (tag_r - ONE);

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = val_r;
    priority if (move_wr) begin
      we    = 1'b1;
      waddr = dst[AW-1:0];
      wdata = rdata_r;
    end else if (cmd.wr_tail) begin
      we    = 1'b1;
      waddr = len_r[AW-1:0];
    end else if (cmd.wr_pos) begin
      we    = 1'b1;
      waddr = p0[AW-1:0];
    end else if (cmd.wr_best) begin
      we    = 1'b1;
      waddr = AW'(len_r - ONE);
      wdata = best_val_r;
    end else begin
      we    = 1'b0;
    end
  end

  always_comb begin
    unique case (cmd.mv_kind)
      sle_pkg::MV_SCAN: begin
        src_nxt = '0;
        cnt_nxt = len_r;
      end
      sle_pkg::MV_UP: begin
        src_nxt = len_r - ONE;
        cnt_nxt = len_r - p0;
      end
      sle_pkg::MV_DEL: begin
        src_nxt = p0 + ONE;
        cnt_nxt = len_r - ONE - p0;
      end
      sle_pkg::MV_MAX: begin
        src_nxt = best_idx_r + ONE;
        cnt_nxt = len_r - ONE - best_idx_r;
      end
      default: begin
        src_nxt = '0;
        cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_len) begin
        len_r <= '0;
      end else if (cmd.inc_len) begin
        len_r <= len_r + ONE;
      end else if (cmd.dec_len) begin
        len_r <= len_r - ONE;
      end
      if (cmd.mv_start) begin
        cnt_r <= cnt_nxt;
      end else if (mv_rd) begin
        cnt_r <= cnt_r - ONE;
      end
      pend_r <= mv_rd && !cmd.mv_start;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      cmd_r        <= in_command;
      pos_r        <= in_position;
      val_r        <= in_value;
      res_status_r <= sle_pkg::ST_OK;
      res_data_r   <= '0;
      res_found_r  <= '0;
    end
    if (cmd.mv_start) begin
      src_r  <= src_nxt;
      kind_r <= cmd.mv_kind;
      if (cmd.mv_kind == sle_pkg::MV_SCAN) begin
        found_v_r <= 1'b0;
      end
    end else if (mv_rd) begin
      src_r <= (kind_r == sle_pkg::MV_UP) ? (src_r - ONE) : (src_r + ONE);
    end
    if (mv_rd) begin
      tag_r <= src_r;
    end
    // Compare stage of a scan: the first match and the first largest element.
    if (pend_r && (kind_r == sle_pkg::MV_SCAN)) begin
      if (!found_v_r && (rdata_r == val_r)) begin
        found_v_r   <= 1'b1;
        found_idx_r <= tag_r;
      end
      if ((tag_r == '0) || (rdata_r > best_val_r)) begin
        best_val_r <= rdata_r;
        best_idx_r <= tag_r;
      end
    end
    if (cmd.set_status) begin
      res_status_r <= cmd.status;
    end
    if (cmd.cap_rd) begin
      res_data_r <= rdata_r;
    end
    if (cmd.take_found) begin
      if (found_v_r) begin
        res_found_r <= sle_pkg::POS_W'(found_idx_r + ONE);
      end else begin
        res_status_r <= sle_pkg::ST_MISS;
      end
    end
    if (cmd.take_best) begin
      res_data_r <= best_val_r;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_data_r   <= res_data_r;
      out_found_r  <= res_found_r;
      out_length_r <= sle_pkg::POS_W'(len_r);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_found  = out_found_r;
  assign out_length = out_length_r;

endmodule

// ===== sv/sle_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_ctrl: command sequencer of the list engine
// Decodes each request, runs the mover phases it needs and hands the result
// to the output register.
// ----------------------------------------------------------------------------
module sle_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  sle_pkg::dp_sts_t sts,
  output sle_pkg::dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD_CAP,
    S_SCAN_WAIT,
    S_SHIFT_WAIT,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        unique case (sts.op)
          sle_pkg::OP_CLEAR: begin
            cmd.clr_len = 1'b1;
          end
          sle_pkg::OP_APPEND: begin
            if (sts.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = sle_pkg::ST_FULL;
            end else begin
              cmd.wr_tail = 1'b1;
              cmd.inc_len = 1'b1;
            end
          end
          sle_pkg::OP_INSERT: begin
            if (sts.bad_ins) begin
              cmd.set_status = 1'b1;
              cmd.status     = sle_pkg::ST_BAD;
            end else if (sts.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = sle_pkg::ST_FULL;
            end else begin
              cmd.mv_start = 1'b1;
              cmd.mv_kind  = sle_pkg::MV_UP;
              state_nxt    = S_SHIFT_WAIT;
            end
          end
          sle_pkg::OP_DELETE, sle_pkg::OP_READ: begin
            if (sts.bad_pos) begin
              cmd.set_status = 1'b1;
              cmd.status     = sle_pkg::ST_BAD;
            end else begin
              state_nxt  = S_RD_CAP;
            end
          end
          sle_pkg::OP_LOCATE: begin
            cmd.mv_start = 1'b1;
            cmd.mv_kind  = sle_pkg::MV_SCAN;
            state_nxt    = S_SCAN_WAIT;
          end
          sle_pkg::OP_MAXEND: begin
            if (sts.empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = sle_pkg::ST_MISS;
            end else begin
              cmd.mv_start = 1'b1;
              cmd.mv_kind  = sle_pkg::MV_SCAN;
              state_nxt    = S_SCAN_WAIT;
            end
          end
          default: begin
          end
        endcase
      end
      S_RD_CAP: begin
        cmd.cap_rd = 1'b1;
        state_nxt  = S_DONE;
        if (sts.op == sle_pkg::OP_DELETE) begin
          cmd.mv_start = 1'b1;
          cmd.mv_kind  = sle_pkg::MV_DEL;
          state_nxt    = S_SHIFT_WAIT;
        end
      end
      S_SCAN_WAIT: begin
        if (!sts.busy) begin
          if (sts.op == sle_pkg::OP_LOCATE) begin
            cmd.take_found = 1'b1;
            state_nxt      = S_DONE;
          end else begin
            cmd.take_best = 1'b1;
            cmd.mv_start  = 1'b1;
            cmd.mv_kind   = sle_pkg::MV_MAX;
            state_nxt     = S_SHIFT_WAIT;
          end
        end
      end
      S_SHIFT_WAIT: begin
        if (!sts.busy) begin
          state_nxt = S_DONE;
          priority if (sts.op == sle_pkg::OP_INSERT) begin
            cmd.wr_pos  = 1'b1;
            cmd.inc_len = 1'b1;
          end else if (sts.op == sle_pkg::OP_DELETE) begin
            cmd.dec_len = 1'b1;
          end else begin
            cmd.wr_best = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/sequential_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_list_engine: ordered list of signed 32-bit elements
//
// Requests arrive on in_chan (command, position, value) and each one produces
// exactly one result on out_chan (status, data_out, found_at, length_now).
// Both channels move a request or result when valid and ready are high.
// Clear and append go from decode straight to the result load, and read first
// captures the stored element. A valid insert or delete also shifts the tail
// behind the position, locate scans the list, and move-max-to-end scans it and
// then shifts the elements behind the maximum down: the element store has one
// write and one registered read port, so the mover walks one element per cycle.
// At reset the length is zero and the result channel is empty; the store
// contents stay undefined and are never read before they are written, so no
// clearing pass runs. While a result waits on a stalled receiver, one further
// request is taken and worked on, and its result is held back until the
// output register is free.
// ----------------------------------------------------------------------------
module sequential_list_engine #(
  parameter int CAPACITY = sle_pkg::DEF_CAPACITY
) (
  input  logic     clk,
  input  logic     rst_n,
  sle_cmd_if.sink  in_chan,
  sle_rsp_if.source out_chan
);

  // Command and status groups between the sequencer and the datapath.
  sle_pkg::dp_cmd_t cmd;
  sle_pkg::dp_sts_t sts;

  // The sequencer decodes each request and steps through its phases: a
  // single read, a scan over the list, and a shift of the tail up or down.
  sle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the store, the length, the mover and the output
  // register that decouples the result channel from the work in progress.
  sle_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_command  (in_chan.command),
    .in_position (in_chan.position),
    .in_value    (in_chan.value),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .out_status  (out_chan.status),
    .out_data    (out_chan.data_out),
    .out_found   (out_chan.found_at),
    .out_length  (out_chan.length_now)
  );

endmodule

// ===== tb/sequential_list_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_list_engine_tb: self-checking bench for the list engine
// A clocked driver feeds command requests from a queue and a clocked monitor
// checks every result against a list model kept inside the bench. A short
// directed run covers the edge cases. A long random run then grows the list
// to full capacity and shrinks it again, with random gaps on both channels
// and one long receiver stall.
// ----------------------------------------------------------------------------
module sequential_list_engine_tb;

  localparam int LIST_CAP     = sle_pkg::DEF_CAPACITY;
  localparam int RANDOM_ITEMS = 1225;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 2 * LIST_CAP + 40;
  localparam int STALL_CYCLES = 400;
  localparam int MAX_PRINTED  = 100;

  // Command code 7 is outside the defined set; the block must treat it as a no-op.
  localparam logic [sle_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;

  typedef struct packed {
    logic [sle_pkg::CMD_W-1:0]         cmd;
    logic [sle_pkg::POS_W-1:0]         pos;
    logic signed [sle_pkg::DATA_W-1:0] val;
  } list_request_t;

  typedef struct packed {
    sle_pkg::status_t                  status;
    logic signed [sle_pkg::DATA_W-1:0] data;
    logic [sle_pkg::POS_W-1:0]         found;
    logic [sle_pkg::POS_W-1:0]         length;
  } list_result_t;

  logic clk;
  logic rst_n;

  sle_cmd_if in_if();
  sle_rsp_if out_if();

  sequential_list_engine uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // The bench's own copy of the list. Only entries below list_len are ever
  // meaningful, which matches the block: it never uses an entry past the length.
  logic signed [sle_pkg::DATA_W-1:0] list_store [LIST_CAP];
  int                                list_len;

  list_request_t cmd_q[$];       // requests waiting to be offered
  list_result_t  expected_q[$];  // predicted results, oldest first

  int  cycle_count;
  int  error_count;
  int  queued_count;
  int  req_count;
  int  rsp_count;
  int  peak_len;
  int  op_seen [8];
  int  status_seen [4];
  bit  req_moved;
  bit  hold_off;
  bit  grow;

  // Clock: 10 ns period.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               expected_q.size());
      $display("sequential_list_engine: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // List model
  // --------------------------------------------------------------------------

  // Takes out the entry at a zero-based index and closes the gap behind it.
  function automatic logic signed [sle_pkg::DATA_W-1:0] remove_entry(int idx);
    logic signed [sle_pkg::DATA_W-1:0] taken;
    taken = list_store[idx];
    for (int j = idx; j + 1 < list_len; j++) list_store[j] = list_store[j + 1];
    list_len--;
    return taken;
  endfunction

  // Applies one command to the model and returns the result the block owes.
  function automatic list_result_t apply_command(logic [sle_pkg::CMD_W-1:0] cmd,
                                                 logic [sle_pkg::POS_W-1:0] pos,
                                                 logic signed [sle_pkg::DATA_W-1:0] val);
    list_result_t res;
    int p;
    int best;
    res.status = sle_pkg::ST_OK;
    res.data   = '0;
    res.found  = '0;
    p = int'(pos);
    case (cmd)
      sle_pkg::OP_CLEAR: begin
        list_len = 0;
      end
      sle_pkg::OP_APPEND: begin
        if (list_len >= LIST_CAP) begin
          res.status = sle_pkg::ST_FULL;
        end else begin
          list_store[list_len] = val;
          list_len++;
        end
      end
      sle_pkg::OP_INSERT: begin
        // A bad position wins over a full list.
        if (p < 1 || p > list_len + 1) begin
          res.status = sle_pkg::ST_BAD;
        end else if (list_len >= LIST_CAP) begin
          res.status = sle_pkg::ST_FULL;
        end else begin
          for (int j = list_len; j >= p; j--) list_store[j] = list_store[j - 1];
          list_store[p - 1] = val;
          list_len++;
        end
      end
      sle_pkg::OP_DELETE: begin
        if (p < 1 || p > list_len) res.status = sle_pkg::ST_BAD;
        else res.data = remove_entry(p - 1);
      end
      sle_pkg::OP_LOCATE: begin
        for (int j = 0; j < list_len; j++) begin
          if (list_store[j] == val && res.found == 0)
            res.found = sle_pkg::POS_W'(j + 1);
        end
        if (res.found == 0) res.status = sle_pkg::ST_MISS;
      end
      sle_pkg::OP_MAXEND: begin
        if (list_len == 0) begin
          res.status = sle_pkg::ST_MISS;
        end else begin
          // Strictly greater keeps the first of several equal maxima.
          best = 0;
          for (int j = 1; j < list_len; j++) begin
            if (list_store[j] > list_store[best]) best = j;
          end
          res.data = remove_entry(best);
          list_store[list_len] = res.data;
          list_len++;
        end
      end
      sle_pkg::OP_READ: begin
        if (p < 1 || p > list_len) res.status = sle_pkg::ST_BAD;
        else res.data = list_store[p - 1];
      end
      default: begin
      end
    endcase
    res.length = sle_pkg::POS_W'(list_len);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Channel activity
  // --------------------------------------------------------------------------

  task automatic report_mismatch(string what);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("ERROR cycle %0d: %s", cycle_count, what);
  endtask

  // Random gaps on about a quarter of the cycles, except inside a quiet
  // stretch where each side runs flat out.
  function automatic bit sender_pause();
    if (req_count >= 600 && req_count < 800) return 1'b0;
    return $urandom_range(0, 99) < 26;
  endfunction

  function automatic bit receiver_pause();
    if (rsp_count >= 600 && rsp_count < 800) return 1'b0;
    return $urandom_range(0, 99) < 26;
  endfunction

  // Driver: a request stays on the channel until a rising edge takes it.
  // Everything changes on the falling edge, well clear of the sampling edge.
  always @(negedge clk) begin : drive_requests
    list_request_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || req_moved) begin
      req_moved = 1'b0;
      // During the long receiver stall the sender keeps offering so that the
      // engine fills its internal slot and has to push back on its input.
      if (cmd_q.size() > 0 && (hold_off || !sender_pause())) begin
        nxt = cmd_q.pop_front();
        in_if.valid    <= 1'b1;
        in_if.command  <= nxt.cmd;
        in_if.position <= nxt.pos;
        in_if.value    <= nxt.val;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_if.ready <= rst_n && !hold_off && !receiver_pause();
  end

  // Monitor: both handshakes are sampled at the rising edge. A result accepted
  // at this edge always belongs to an earlier request, so it is checked first.
  always @(posedge clk) begin : watch_channels
    list_result_t want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        rsp_count++;
        if (expected_q.size() == 0) begin
          report_mismatch("result arrived with no request outstanding");
        end else begin
          want = expected_q.pop_front();
          if (out_if.status !== want.status)
            report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                      rsp_count, out_if.status, want.status));
          if (out_if.data_out !== want.data)
            report_mismatch($sformatf("result %0d: data_out %0d, expected %0d",
                                      rsp_count, out_if.data_out, want.data));
          if (out_if.found_at !== want.found)
            report_mismatch($sformatf("result %0d: found_at %0d, expected %0d",
                                      rsp_count, out_if.found_at, want.found));
          if (out_if.length_now !== want.length)
            report_mismatch($sformatf("result %0d: length_now %0d, expected %0d",
                                      rsp_count, out_if.length_now, want.length));
        end
      end
      if (in_if.valid && in_if.ready) begin
        want = apply_command(in_if.command, in_if.position, in_if.value);
        expected_q.push_back(want);
        op_seen[in_if.command]++;
        status_seen[want.status]++;
        if (list_len > peak_len) peak_len = list_len;
        req_count++;
        req_moved = 1'b1;
      end
    end
  end

  // One long receiver stall, timed in cycles by its own process.
  initial begin
    hold_off = 1'b0;
    while (rsp_count < 300) @(posedge clk);
    hold_off = 1'b1;
    repeat (STALL_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  function automatic void queue_request(logic [sle_pkg::CMD_W-1:0] cmd,
                                        logic [sle_pkg::POS_W-1:0] pos,
                                        logic signed [sle_pkg::DATA_W-1:0] val);
    cmd_q.push_back('{cmd: cmd, pos: pos, val: val});
    queued_count++;
  endfunction

  // Mostly legal positions, with the two ends favored; now and then any
  // 8-bit value, which exercises the position checks and the upper bits.
  function automatic logic [sle_pkg::POS_W-1:0] pick_position(int span);
    int r;
    r = $urandom_range(0, 99);
    if (span < 1 || r < 12) return sle_pkg::POS_W'($urandom_range(0, 255));
    if (r < 24) return sle_pkg::POS_W'(span);
    if (r < 34) return sle_pkg::POS_W'(1);
    return sle_pkg::POS_W'($urandom_range(1, span));
  endfunction

  // A narrow band of small values makes repeats and ties for the maximum
  // common; the rest is the full 32-bit range and its corners.
  function automatic logic signed [sle_pkg::DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return sle_pkg::DATA_W'(int'($urandom_range(0, 15)) - 8);
    if (r < 45) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7FFF_FFFF;
        1: return 32'sh8000_0000;
        2: return '0;
        default: return '1;
      endcase
    end
    return $urandom();
  endfunction

  // Builds one random request. The list alternates between a growing phase,
  // which drives it to capacity and keeps hitting the full cases for a while,
  // and a shrinking phase that drains it again.
  function automatic list_request_t make_request();
    list_request_t req;
    int r;
    if (grow && list_len >= LIST_CAP && $urandom_range(0, 14) == 0) grow = 1'b0;
    if (!grow && list_len <= 2) grow = 1'b1;
    r = $urandom_range(0, 99);
    if (grow) begin
      if (r < 40)      req.cmd = sle_pkg::OP_APPEND;
      else if (r < 70) req.cmd = sle_pkg::OP_INSERT;
      else if (r < 76) req.cmd = sle_pkg::OP_DELETE;
      else if (r < 84) req.cmd = sle_pkg::OP_LOCATE;
      else if (r < 89) req.cmd = sle_pkg::OP_MAXEND;
      else if (r < 97) req.cmd = sle_pkg::OP_READ;
      else             req.cmd = CMD_UNUSED;
    end else begin
      if (r < 10)      req.cmd = sle_pkg::OP_APPEND;
      else if (r < 20) req.cmd = sle_pkg::OP_INSERT;
      else if (r < 60) req.cmd = sle_pkg::OP_DELETE;
      else if (r < 72) req.cmd = sle_pkg::OP_LOCATE;
      else if (r < 80) req.cmd = sle_pkg::OP_MAXEND;
      else if (r < 94) req.cmd = sle_pkg::OP_READ;
      else if (r < 96) req.cmd = CMD_UNUSED;
      else             req.cmd = sle_pkg::OP_CLEAR;
    end
    req.val = pick_value();
    if (req.cmd == sle_pkg::OP_INSERT) req.pos = pick_position(list_len + 1);
    else                               req.pos = pick_position(list_len);
    // Locate mostly asks for something that is really in the list.
    if (req.cmd == sle_pkg::OP_LOCATE && list_len > 0 && $urandom_range(0, 99) < 60)
      req.val = list_store[$urandom_range(0, list_len - 1)];
    return req;
  endfunction

  initial begin
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.command  = '0;
    in_if.position = '0;
    in_if.value    = '0;
    out_if.ready   = 1'b0;
    list_len       = 0;
    grow           = 1'b1;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: empty-list errors, position bounds, extreme values,
    // first-match locate, the first of two equal maxima, and the unused code.
    queue_request(sle_pkg::OP_CLEAR,  8'd0,   32'sd0);
    queue_request(sle_pkg::OP_READ,   8'd1,   32'sd0);          // read on an empty list
    queue_request(sle_pkg::OP_DELETE, 8'd1,   32'sd0);          // delete on an empty list
    queue_request(sle_pkg::OP_LOCATE, 8'd0,   32'sd0);          // nothing to find
    queue_request(sle_pkg::OP_MAXEND, 8'd0,   32'sd0);          // max of an empty list
    queue_request(sle_pkg::OP_INSERT, 8'd0,   32'sd5);          // position zero
    queue_request(sle_pkg::OP_INSERT, 8'd2,   32'sd5);          // one past length + 1
    queue_request(sle_pkg::OP_INSERT, 8'd1,   32'sh7FFF_FFFF);
    queue_request(sle_pkg::OP_APPEND, 8'd0,   32'sh8000_0000);
    queue_request(sle_pkg::OP_APPEND, 8'd0,   '1);
    queue_request(sle_pkg::OP_INSERT, 8'd4,   32'sd0);          // insert at the tail
    queue_request(sle_pkg::OP_INSERT, 8'd2,   32'sh7FFF_FFFF);  // second copy of the max
    queue_request(sle_pkg::OP_READ,   8'd5,   32'sd0);
    queue_request(sle_pkg::OP_READ,   8'd6,   32'sd0);          // just past the end
    queue_request(sle_pkg::OP_READ,   8'd255, 32'sd0);
    queue_request(sle_pkg::OP_LOCATE, 8'd0,   32'sh7FFF_FFFF);  // first of two matches
    queue_request(sle_pkg::OP_LOCATE, 8'd0,   32'sd12345);
    queue_request(sle_pkg::OP_MAXEND, 8'd0,   32'sd0);          // moves the first max
    queue_request(sle_pkg::OP_DELETE, 8'd1,   32'sd0);
    queue_request(sle_pkg::OP_DELETE, 8'd4,   32'sd0);          // delete the last entry
    queue_request(sle_pkg::OP_DELETE, 8'd0,   32'sd0);
    queue_request(CMD_UNUSED,         8'd255, '1);
    queue_request(sle_pkg::OP_LOCATE, 8'd0,   '1);
    queue_request(sle_pkg::OP_CLEAR,  8'd0,   32'sd0);
    queue_request(sle_pkg::OP_READ,   8'd1,   32'sd0);          // read after clear

    // Random part, produced a few requests ahead of the driver so that the
    // choices follow the list as it stands.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      while (cmd_q.size() >= 2) @(posedge clk);
      cmd_q.push_back(make_request());
      queued_count++;
    end

    while (req_count < queued_count || expected_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests: clear %0d, append %0d, insert %0d, delete %0d,",
             req_count, op_seen[sle_pkg::OP_CLEAR], op_seen[sle_pkg::OP_APPEND],
             op_seen[sle_pkg::OP_INSERT], op_seen[sle_pkg::OP_DELETE]);
    $display("  locate %0d, max-to-end %0d, read %0d, unused %0d;",
             op_seen[sle_pkg::OP_LOCATE], op_seen[sle_pkg::OP_MAXEND],
             op_seen[sle_pkg::OP_READ], op_seen[CMD_UNUSED]);
    $display("  status ok %0d, bad %0d, full %0d, miss %0d; longest list %0d",
             status_seen[sle_pkg::ST_OK], status_seen[sle_pkg::ST_BAD],
             status_seen[sle_pkg::ST_FULL], status_seen[sle_pkg::ST_MISS], peak_len);
    if (error_count == 0) begin
      $display("sequential_list_engine: match");
    end else begin
      $display("%0d mismatches found", error_count);
      $display("sequential_list_engine: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/sle_pkg.sv
sv/sle_cmd_if.sv
sv/sle_rsp_if.sv
sv/sle_datapath.sv
sv/sle_ctrl.sv
sv/sequential_list_engine.sv
tb/sequential_list_engine_tb.sv
